>>> design/ohacc_pkg.sv
// Shared types, codes and constants of the orientation histogram accumulator.
package ohacc_pkg;

   localparam int OHACC_MAX_BINS   = 64;
   localparam int OHACC_TOTAL_BITS = 48;

   // Field widths fixed by the item formats.
   localparam int ANGLE_W     = 16;
   localparam int SAMPLE_W    = 16;
   localparam int SELECT_W    = 6;
   localparam int COUNT_W     = 7;
   localparam int OUT_TOTAL_W = 48;

   localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = 7'd36;

   localparam logic [1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      SLOT_PREV,
      SLOT_CENTRE,
      SLOT_NEXT,
      SLOT_SEL
   } slot_type;

   typedef struct packed {
      logic [1:0]          operation;
      logic [ANGLE_W-1:0]  angle_turns;
      logic [SAMPLE_W-1:0] sample_value;
      logic [SELECT_W-1:0] bin_select;
   } req_type;

   typedef struct packed {
      logic [SELECT_W-1:0]    bin_index;
      logic [OUT_TOTAL_W-1:0] bin_total;
      logic                   index_error;
   } rsp_type;

   typedef struct packed {
      logic     load;
      logic     clr_en;
      logic     map;
      logic     rd_en;
      slot_type slot;
      logic     acc_wr;
      logic     respond;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
   } sts_type;

endpackage

>>> design/ohacc_ctrl.sv
// Controller state machine of the orientation histogram accumulator.
module ohacc_ctrl
   import ohacc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] operation,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_ACC0,
      ST_ACC1,
      ST_ACC2,
      ST_ACC3,
      ST_RDQ,
      ST_RSP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (operation) inside
                  OP_ACCUMULATE:          state_in = ST_MAP;
                  OP_READ, OP_READ_CLEAR: state_in = ST_RDQ;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_ACC0;
         end
         ST_ACC0: begin
            cmd.rd_en = 1'b1;
            cmd.slot  = SLOT_PREV;
            state_in  = ST_ACC1;
         end
         ST_ACC1: begin
            cmd.acc_wr = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.slot   = SLOT_CENTRE;
            state_in   = ST_ACC2;
         end
         ST_ACC2: begin
            cmd.acc_wr = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.slot   = SLOT_NEXT;
            state_in   = ST_ACC3;
         end
         ST_ACC3: begin
            cmd.acc_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_RDQ: begin
            cmd.rd_en = 1'b1;
            cmd.slot  = SLOT_SEL;
            state_in  = ST_RSP;
         end
         ST_RSP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

>>> design/ohacc_dp.sv
// Datapath of the orientation histogram accumulator: bin mapping, weights and the total store.
module ohacc_dp
   import ohacc_pkg::*;
#(
   parameter int MAX_BINS   = OHACC_MAX_BINS,
   parameter int TOTAL_BITS = OHACC_TOTAL_BITS
)
(
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  logic               csr_valid,
   input  logic [COUNT_W-1:0] csr_data,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int N_W    = $clog2(MAX_BINS + 1);
   localparam int CNT_W  = (N_W > COUNT_W) ? N_W : COUNT_W;
   localparam int P_W    = CNT_W + ANGLE_W;
   localparam int W_W    = ANGLE_W + 1;
   localparam int PR_W   = SAMPLE_W + W_W;
   localparam int SUM_W  = ((TOTAL_BITS > PR_W) ? TOTAL_BITS : PR_W) + 1;
   localparam logic [SUM_W-1:0] TOP  = (SUM_W'(1) << TOTAL_BITS) - SUM_W'(1);
   localparam logic [W_W-1:0]   HALF = W_W'(1) << (ANGLE_W - 1);
   localparam logic [W_W-1:0]   ONE  = W_W'(1) << ANGLE_W;

   logic [TOTAL_BITS-1:0] mem [MAX_BINS];

   req_type               req_ff;
   logic [COUNT_W-1:0]    bc_ff;
   logic [BIN_W-1:0]      clr_ff;
   logic [CNT_W-1:0]      centre_ff;
   logic [ANGLE_W-1:0]    s_ff;
   logic [BIN_W-1:0]      rd_addr_ff;
   logic [PR_W-1:0]       prod_ff;
   logic [TOTAL_BITS-1:0] rdata_ff;
   logic                  fwd_vld_ff;
   logic [BIN_W-1:0]      fwd_addr_ff;
   logic [TOTAL_BITS-1:0] fwd_sum_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]      bc_ext, n, n_m1;
   logic [P_W-1:0]        pos;
   logic [CNT_W-1:0]      centre_raw, prev_bin, next_bin, addr_full;
   logic [W_W-1:0]        s_ext, w_prev, w_next, w_centre, weight;
   logic [PR_W-1:0]       prod_in;
   logic [TOTAL_BITS-1:0] cur;
   logic [SUM_W-1:0]      sum_raw, sum_sat;
   logic [TOTAL_BITS-1:0] sum_val;
   logic                  sel_err;
   logic [63:0]           total64;
   logic                  mem_we;
   logic [BIN_W-1:0]      mem_waddr;
   logic [TOTAL_BITS-1:0] mem_wdata;

   // Effective bin count: zero means one bin, large values stop at the store depth.
   always_comb begin
      bc_ext = CNT_W'(bc_ff);
      if (bc_ff == '0) begin
         n = CNT_W'(1);
      end else if (bc_ext > CNT_W'(MAX_BINS)) begin
         n = CNT_W'(MAX_BINS);
      end else begin
         n = bc_ext;
      end
      n_m1 = n - CNT_W'(1);
   end

   assign pos        = P_W'(n) * P_W'(req_ff.angle_turns);
   assign centre_raw = pos[P_W-1:ANGLE_W];

   assign prev_bin = (centre_ff == '0) ? n_m1 : centre_ff - CNT_W'(1);
   assign next_bin = (centre_ff == n_m1) ? '0 : centre_ff + CNT_W'(1);

   assign s_ext    = W_W'(s_ff);
   assign w_prev   = (s_ext < HALF) ? HALF - s_ext : '0;
   assign w_next   = (s_ext > HALF) ? s_ext - HALF : '0;
   assign w_centre = ONE - w_prev - w_next;

   always_comb begin
      case (cmd.slot)
         SLOT_PREV: begin
            addr_full = prev_bin;
            weight    = w_prev;
         end
         SLOT_CENTRE: begin
            addr_full = centre_ff;
            weight    = w_centre;
         end
         SLOT_NEXT: begin
            addr_full = next_bin;
            weight    = w_next;
         end
         default: begin
            addr_full = CNT_W'(req_ff.bin_select);
            weight    = '0;
         end
      endcase
   end

   assign prod_in = PR_W'(req_ff.sample_value) * PR_W'(weight);

   // The previous write is not yet visible in the read data when both hit the same bin.
   assign cur     = (fwd_vld_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_sum_ff : rdata_ff;
   assign sum_raw = SUM_W'(cur) + SUM_W'(prod_ff);
   assign sum_sat = (sum_raw > TOP) ? TOP : sum_raw;
   assign sum_val = sum_sat[TOTAL_BITS-1:0];

   assign sel_err = (CNT_W'(req_ff.bin_select) >= n);
   assign total64 = 64'(rdata_ff);

   always_comb begin
      rsp_data_in.bin_index   = req_ff.bin_select;
      rsp_data_in.index_error = sel_err;
      rsp_data_in.bin_total   = sel_err ? '0 : total64[OUT_TOTAL_W-1:0];
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = rd_addr_ff;
      mem_wdata = '0;
      if (cmd.clr_en) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end else if (cmd.acc_wr) begin
         mem_we    = 1'b1;
         mem_wdata = sum_val;
      end else if (cmd.respond && (req_ff.operation == OP_READ_CLEAR) && !sel_err) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_full[BIN_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff        <= BIN_COUNT_RESET;
         clr_ff       <= '0;
         fwd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            bc_ff <= csr_data;
         end
         if (cmd.clr_en) begin
            clr_ff <= clr_ff + BIN_W'(1);
         end
         if (cmd.map) begin
            fwd_vld_ff <= 1'b0;
         end else if (cmd.acc_wr) begin
            fwd_vld_ff <= 1'b1;
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.map) begin
         centre_ff <= (centre_raw >= n) ? n_m1 : centre_raw;
         s_ff      <= pos[ANGLE_W-1:0];
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= addr_full[BIN_W-1:0];
         prod_ff    <= prod_in;
      end
      if (cmd.acc_wr) begin
         fwd_addr_ff <= rd_addr_ff;
         fwd_sum_ff  <= sum_val;
      end
      if (cmd.respond) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sts.clr_last = (clr_ff == BIN_W'(MAX_BINS - 1));
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

>>> design/orientation_histogram_accumulator.sv
// Top level of the orientation histogram accumulator: controller, datapath and checks.
//
// The block keeps a circular histogram of weighted totals, one per bin, in a memory with
// one read and one write port. An item is offered on req_data with start and is taken at
// a rising edge where start is high and busy is low. An accumulate item splits its
// magnitude over the bin under the angle and its two neighbors and adds each share with
// saturation; it gives no result. A read item returns one bin's total; a read-and-clear
// item also zeroes it. Each result is shown on rsp_data for exactly one cycle with
// rsp_valid high, registered after the item passes the read and response states. The
// receiver cannot stall, so results never wait. An accumulate keeps busy high while it
// maps the angle onto bins and then does three reads and three write-backs overlapped
// one bin per cycle, each write going out while the next bin is read. A read item holds
// busy while it reads the bin and registers the result. No new item is taken while
// busy is high; an unused operation code is dropped at once without raising busy.
// The bin count register is written over csr_data/csr_valid and csr_ready is always
// high; the user must write it only while no item is in flight. The block itself does
// not enforce this. After reset the block walks the memory and zeroes one bin per cycle,
// holding busy high; configuration writes are still taken.
module orientation_histogram_accumulator
   import ohacc_pkg::*;
#(
   parameter int MAX_BINS   = OHACC_MAX_BINS,
   parameter int TOTAL_BITS = OHACC_TOTAL_BITS
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // The controller sees the start strobe, the operation code of the item and the clear status.
   ohacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   // The datapath owns the request register, the bin count, the weights and the store.
   ohacc_dp #(
      .MAX_BINS   (MAX_BINS),
      .TOTAL_BITS (TOTAL_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Configuration is never held off.
   assign csr_ready = 1'b1;

`ifndef SYNTHESIS
   a_rsp_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_data.operation == OP_READ) ||
                          (req_data.operation == OP_READ_CLEAR))) |-> ##3 rsp_valid)
      else $error("read item did not give a result three cycles after it was taken");

   a_error_zero_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.index_error) |-> (rsp_data.bin_total == '0))
      else $error("out of range read returned a nonzero total");

   a_no_result_when_accumulating: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.operation == OP_ACCUMULATE)) |=> ##1 !rsp_valid)
      else $error("accumulate item produced a result");
`endif

endmodule
